// ===== design/ubxp_pkg.sv =====
package ubxp_pkg;

  localparam int unsigned BUFFER_DEPTH_DEF = 256;

  localparam logic [7:0] SYNC_FIRST  = 8'hB5;
  localparam logic [7:0] SYNC_SECOND = 8'h62;
  localparam logic [7:0] CLASS_NAV   = 8'h01;
  localparam logic [7:0] ID_NAV_PVT  = 8'h07;
  localparam logic [15:0] PVT_MIN_LEN = 16'd80;
  localparam int unsigned PVT_FIELDS = 22;

  localparam int unsigned FIDX_W = 5;
  localparam int unsigned OFF_W  = 7;

  localparam logic [4:0] CODE_SUMMARY = 5'd0;

  typedef enum logic [3:0] {
    PH_SYNC1,
    PH_SYNC2,
    PH_CLASS,
    PH_ID,
    PH_LEN_LO,
    PH_LEN_HI,
    PH_PAYLOAD,
    PH_CK_A,
    PH_CK_B,
    PH_FETCH,
    PH_CAPT,
    PH_EMIT
  } state_t;

  typedef struct packed {
    logic clr_sum;
    logic add_sum;
    logic ld_class;
    logic ld_id;
    logic ld_len_lo;
    logic ld_len_hi;
    logic store;
    logic ld_cka;
    logic emit_sum;
    logic field_init;
    logic capture;
    logic emit_field;
  } cmd_t;

  typedef struct packed {
    logic is_sync1;
    logic is_sync2;
    logic len_zero;
    logic pay_done;
    logic ck_good;
    logic is_pvt;
    logic byte_last;
    logic field_last;
    logic out_free;
  } sts_t;

  function automatic logic [OFF_W-1:0] pvt_offset(input logic [FIDX_W-1:0] idx);
    logic [OFF_W-1:0] r;
    case (idx)
      5'd0:    r = 7'd20;
      5'd1:    r = 7'd21;
      5'd2:    r = 7'd23;
      5'd3:    r = 7'd24;
      5'd4:    r = 7'd28;
      5'd5:    r = 7'd32;
      5'd6:    r = 7'd36;
      5'd7:    r = 7'd40;
      5'd8:    r = 7'd44;
      5'd9:    r = 7'd48;
      5'd10:   r = 7'd52;
      5'd11:   r = 7'd56;
      5'd12:   r = 7'd60;
      5'd13:   r = 7'd76;
      5'd14:   r = 7'd78;
      5'd15:   r = 7'd4;
      5'd16:   r = 7'd6;
      5'd17:   r = 7'd7;
      5'd18:   r = 7'd8;
      5'd19:   r = 7'd9;
      5'd20:   r = 7'd10;
      5'd21:   r = 7'd0;
      default: r = 7'd0;
    endcase
    return r;
  endfunction

  // size minus one
  function automatic logic [1:0] pvt_size_m1(input logic [FIDX_W-1:0] idx);
    logic [1:0] r;
    case (idx)
      5'd3, 5'd4, 5'd5, 5'd6, 5'd7, 5'd8, 5'd9, 5'd10, 5'd11, 5'd12: r = 2'd3;
      5'd13, 5'd14, 5'd15, 5'd21: r = 2'd1;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== design/ubxp_ctrl.sv =====
module ubxp_ctrl
  import ubxp_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state, state_next;
  logic   acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= PH_SYNC1;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b0;
    case (state)
      PH_FETCH, PH_CAPT, PH_EMIT: in_stall = 1'b1;
      PH_CK_B:                    in_stall = !sts.out_free;
      default:                    in_stall = 1'b0;
    endcase
    acc = in_valid && !in_stall;
    case (state)
      PH_SYNC2: begin
        if (acc) begin
          if (sts.is_sync2) begin
            cmd.clr_sum = 1'b1;
            state_next  = PH_CLASS;
          end else begin
            state_next = PH_SYNC1;
          end
        end
      end
      PH_CLASS: begin
        if (acc) begin
          cmd.ld_class = 1'b1;
          cmd.add_sum  = 1'b1;
          state_next   = PH_ID;
        end
      end
      PH_ID: begin
        if (acc) begin
          cmd.ld_id   = 1'b1;
          cmd.add_sum = 1'b1;
          state_next  = PH_LEN_LO;
        end
      end
      PH_LEN_LO: begin
        if (acc) begin
          cmd.ld_len_lo = 1'b1;
          cmd.add_sum   = 1'b1;
          state_next    = PH_LEN_HI;
        end
      end
      PH_LEN_HI: begin
        if (acc) begin
          cmd.ld_len_hi = 1'b1;
          cmd.add_sum   = 1'b1;
          state_next    = sts.len_zero ? PH_CK_A : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        if (acc) begin
          cmd.store   = 1'b1;
          cmd.add_sum = 1'b1;
          if (sts.pay_done) begin
            state_next = PH_CK_A;
          end
        end
      end
      PH_CK_A: begin
        if (acc) begin
          cmd.ld_cka = 1'b1;
          state_next = PH_CK_B;
        end
      end
      PH_CK_B: begin
        if (acc) begin
          if (sts.ck_good && sts.is_pvt) begin
            cmd.field_init = 1'b1;
            state_next     = PH_FETCH;
          end else begin
            cmd.emit_sum = 1'b1;
            state_next   = PH_SYNC1;
          end
        end
      end
      PH_FETCH: begin
        state_next = PH_CAPT;
      end
      PH_CAPT: begin
        cmd.capture = 1'b1;
        state_next  = sts.byte_last ? PH_EMIT : PH_FETCH;
      end
      PH_EMIT: begin
        if (sts.out_free) begin
          cmd.emit_field = 1'b1;
          state_next     = sts.field_last ? PH_SYNC1 : PH_FETCH;
        end
      end
      default: begin
        if (acc) begin
          state_next = sts.is_sync1 ? PH_SYNC2 : PH_SYNC1;
        end
      end
    endcase
  end

`ifndef ASSERT_OFF
  a_ckb_room: assert property (@(posedge clk) disable iff (rst)
    (state == PH_CK_B && in_valid && !in_stall) |-> sts.out_free)
    else $error("frame end taken with output register busy");

  a_emit_exit: assert property (@(posedge clk) disable iff (rst)
    (state == PH_EMIT && sts.out_free) |=> (state == PH_FETCH || state == PH_SYNC1))
    else $error("bad exit from field emit");
`endif

endmodule

// ===== design/ubxp_dp.sv =====
module ubxp_dp
  import ubxp_pkg::*;
#(
  parameter int unsigned BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  rx_byte,
  input  cmd_t        cmd,
  output sts_t        sts,
  output logic [7:0]  frame_class,
  output logic [7:0]  msg_id,
  output logic [15:0] payload_length,
  output logic        checksum_ok,
  output logic [4:0]  field_code,
  output logic [31:0] field_value,
  output logic        last,
  output logic        out_valid,
  input  logic        out_stall
);

  localparam int unsigned AW = $clog2(BUFFER_DEPTH);

  logic [7:0]  mem [BUFFER_DEPTH];
  logic [7:0]  rd_data;
  logic [AW-1:0] rd_addr;

  logic [7:0]  held_class;
  logic [7:0]  held_id;
  logic [15:0] held_length;
  logic [15:0] bytes_seen;
  logic [15:0] bytes_seen_next;
  logic [7:0]  sum_a;
  logic [7:0]  sum_b;
  logic [7:0]  sum_a_next;
  logic [7:0]  received_sum_a;
  logic [FIDX_W-1:0] fidx;
  logic [1:0]  bidx;
  logic [31:0] acc_val;

  assign sum_a_next      = sum_a + rx_byte;
  assign bytes_seen_next = bytes_seen + 16'd1;
  assign rd_addr         = AW'(pvt_offset(fidx)) + AW'(bidx);

  assign sts.is_sync1   = (rx_byte == SYNC_FIRST);
  assign sts.is_sync2   = (rx_byte == SYNC_SECOND);
  assign sts.len_zero   = ({rx_byte, held_length[7:0]} == 16'd0);
  assign sts.pay_done   = (bytes_seen_next >= held_length);
  assign sts.ck_good    = (received_sum_a == sum_a) && (rx_byte == sum_b);
  assign sts.is_pvt     = (held_class == CLASS_NAV) && (held_id == ID_NAV_PVT) &&
                          (held_length >= PVT_MIN_LEN);
  assign sts.byte_last  = (bidx == pvt_size_m1(fidx));
  assign sts.field_last = (fidx == FIDX_W'(PVT_FIELDS - 1));
  assign sts.out_free   = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (cmd.store && (bytes_seen < 16'(BUFFER_DEPTH))) begin
      mem[bytes_seen[AW-1:0]] <= rx_byte;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_sum) begin
      sum_a <= 8'd0;
      sum_b <= 8'd0;
    end else if (cmd.add_sum) begin
      sum_a <= sum_a_next;
      sum_b <= sum_b + sum_a_next;
    end
    if (cmd.ld_class) begin
      held_class <= rx_byte;
    end
    if (cmd.ld_id) begin
      held_id <= rx_byte;
    end
    if (cmd.ld_len_lo) begin
      held_length <= {8'd0, rx_byte};
    end
    if (cmd.ld_len_hi) begin
      held_length[15:8] <= rx_byte;
      bytes_seen        <= 16'd0;
    end
    if (cmd.store) begin
      bytes_seen <= bytes_seen_next;
    end
    if (cmd.ld_cka) begin
      received_sum_a <= rx_byte;
    end
    if (cmd.field_init) begin
      fidx <= '0;
      bidx <= 2'd0;
    end
    if (cmd.capture) begin
      bidx <= sts.byte_last ? 2'd0 : bidx + 2'd1;
      case (bidx)
        2'd0:    acc_val <= {24'd0, rd_data};
        2'd1:    acc_val[15:8] <= rd_data;
        2'd2:    acc_val[23:16] <= rd_data;
        default: acc_val[31:24] <= rd_data;
      endcase
    end
    if (cmd.emit_field) begin
      fidx <= fidx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_sum || cmd.emit_field) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_sum) begin
      frame_class    <= held_class;
      msg_id         <= held_id;
      payload_length <= held_length;
      checksum_ok    <= sts.ck_good;
      field_code     <= CODE_SUMMARY;
      field_value    <= 32'd0;
      last           <= 1'b1;
    end else if (cmd.emit_field) begin
      frame_class    <= held_class;
      msg_id         <= held_id;
      payload_length <= held_length;
      checksum_ok    <= 1'b1;
      field_code     <= fidx + 1'b1;
      field_value    <= acc_val;
      last           <= sts.field_last;
    end
  end

`ifndef ASSERT_OFF
  a_field_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && field_code != CODE_SUMMARY) |-> checksum_ok)
    else $error("decoded field from frame with bad checksum");

  a_run_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last && field_code != CODE_SUMMARY) |-> (field_code == 5'(PVT_FIELDS)))
    else $error("field run ended early");

  a_summary: assert property (@(posedge clk) disable iff (rst)
    (out_valid && field_code == CODE_SUMMARY) |-> (last && field_value == 32'd0))
    else $error("malformed frame summary");
`endif

endmodule

// ===== design/ubx_frame_parser_pvt_extract_top.sv =====
// UBX frame parser: takes one received byte per cycle while in_stall is low, hunts for the sync
// pair, checks the Fletcher-8 sum and answers on the second checksum byte with either one frame
// summary (field_code 0) or, for a good NAV-PVT frame with a payload of at least 80 bytes, a run
// of 22 decoded fields, the last marked by last. The field run is read from the payload memory
// one byte per read: each byte is fetched and then captured, and each field is emitted once the
// output register is free. in_stall is held high for the whole run.
// in_stall also stays high on the second checksum byte until the output register is free.
module ubx_frame_parser_pvt_extract_top
  import ubxp_pkg::*;
#(
  parameter int unsigned BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  frame_class,
  output logic [7:0]  msg_id,
  output logic [15:0] payload_length,
  output logic        checksum_ok,
  output logic [4:0]  field_code,
  output logic [31:0] field_value,
  output logic        last
);

  cmd_t cmd;
  sts_t sts;

  ubxp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  ubxp_dp #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .rx_byte        (rx_byte),
    .cmd            (cmd),
    .sts            (sts),
    .frame_class    (frame_class),
    .msg_id         (msg_id),
    .payload_length (payload_length),
    .checksum_ok    (checksum_ok),
    .field_code     (field_code),
    .field_value    (field_value),
    .last           (last),
    .out_valid      (out_valid),
    .out_stall      (out_stall)
  );

endmodule
